@@ design/sidta_pkg.sv @@
// shared types and constants for the signed integer to decimal ascii converter
package sidta_pkg;

  // character codes, already reduced to six bits
  localparam logic [5:0] CHAR_MINUS = 6'd45;
  localparam logic [5:0] CHAR_ZERO  = 6'd48;

  // width of one bcd digit
  localparam int unsigned DIGIT_W = 4;

  // controller to datapath commands
  typedef struct packed {
    logic load;        // take a new value, clear the bcd register
    logic step;        // one double-dabble step
    logic skip;        // drop a leading zero digit
    logic emit_sign;   // put a minus sign into the output register
    logic emit_digit;  // put the top digit into the output register
  } sidta_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic negative;    // value taken was negative
    logic conv_last;   // the current step is the final conversion step
    logic top_zero;    // top bcd digit is zero
    logic dig_one;     // one digit remains to be emitted
    logic out_free;    // output register can take a beat this cycle
  } sidta_sts_t;

endpackage

@@ design/sidta_if.sv @@
// valid/ready channel interfaces for the integer input and the character output

interface sidta_value_if #(
  parameter int unsigned VALUE_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface sidta_char_if;
  logic       valid;
  logic       ready;
  logic [5:0] character;
  logic       last;

  modport source (output valid, output character, output last, input ready);
  modport sink   (input valid, input character, input last, output ready);
endinterface

@@ design/sidta_ctrl.sv @@
// controller state machine sequencing conversion and character output
module sidta_ctrl (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  sidta_pkg::sidta_sts_t   sts_i,
  output sidta_pkg::sidta_cmd_t   cmd_o
);
  import sidta_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIGN,
    ST_SKIP,
    ST_EMIT
  } state_e;

  state_e state_q, state_d;

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CONV;
        end
      end
      ST_CONV: begin
        cmd_o.step = 1'b1;
        if (sts_i.conv_last) begin
          state_d = ST_SIGN;
        end
      end
      ST_SIGN: begin
        if (!sts_i.negative) begin
          state_d = ST_SKIP;
        end else if (sts_i.out_free) begin
          cmd_o.emit_sign = 1'b1;
          state_d         = ST_SKIP;
        end
      end
      ST_SKIP: begin
        if (sts_i.top_zero && !sts_i.dig_one) begin
          cmd_o.skip = 1'b1;
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit_digit = 1'b1;
          if (sts_i.dig_one) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ design/sidta_dp.sv @@
// datapath: magnitude, bit-serial double-dabble bcd register and output register
module sidta_dp #(
  parameter int unsigned VALUE_WIDTH = 32,
  parameter int unsigned NUM_DIGITS  = 10
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic signed [VALUE_WIDTH-1:0] value_i,
  input  sidta_pkg::sidta_cmd_t         cmd_i,
  output sidta_pkg::sidta_sts_t         sts_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [5:0]                    character_o,
  output logic                          last_o
);
  import sidta_pkg::*;

  localparam int unsigned BCD_W  = NUM_DIGITS * DIGIT_W;
  localparam int unsigned BCNT_W = $clog2(VALUE_WIDTH + 1);
  localparam int unsigned DCNT_W = $clog2(NUM_DIGITS + 1);

  logic [VALUE_WIDTH-1:0] mag_q;
  logic [BCD_W-1:0]       bcd_q, bcd_adj;
  logic [BCNT_W-1:0]      bcnt_q;
  logic [DCNT_W-1:0]      dcnt_q;
  logic                   neg_q;
  logic                   out_valid_q;
  logic [5:0]             char_q;
  logic                   last_q;
  logic [DIGIT_W-1:0]     top_digit;

  // add three to every digit of five or more before the shift
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd_q[i*DIGIT_W +: DIGIT_W] >= 4'd5) begin
        bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd_q[i*DIGIT_W +: DIGIT_W] + 4'd3;
      end else begin
        bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd_q[i*DIGIT_W +: DIGIT_W];
      end
    end
  end

  assign top_digit = bcd_q[BCD_W-1 -: DIGIT_W];

  // status towards the controller
  always_comb begin
    sts_o.negative  = neg_q;
    sts_o.conv_last = (bcnt_q == BCNT_W'(1));
    sts_o.top_zero  = (top_digit == '0);
    sts_o.dig_one   = (dcnt_q == DCNT_W'(1));
    sts_o.out_free  = !out_valid_q || out_ready_i;
  end

  // conversion registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bcnt_q <= '0;
      dcnt_q <= '0;
      neg_q  <= 1'b0;
    end else if (cmd_i.load) begin
      neg_q  <= value_i[VALUE_WIDTH-1];
      bcnt_q <= BCNT_W'(VALUE_WIDTH);
      dcnt_q <= DCNT_W'(NUM_DIGITS);
    end else if (cmd_i.step) begin
      bcnt_q <= bcnt_q - BCNT_W'(1);
    end else if (cmd_i.skip || cmd_i.emit_digit) begin
      dcnt_q <= dcnt_q - DCNT_W'(1);
    end
  end

  // magnitude and bcd payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mag_q <= value_i[VALUE_WIDTH-1] ? (~value_i + VALUE_WIDTH'(1)) : value_i;
      bcd_q <= '0;
    end else if (cmd_i.step) begin
      mag_q <= {mag_q[VALUE_WIDTH-2:0], 1'b0};
      bcd_q <= {bcd_adj[BCD_W-2:0], mag_q[VALUE_WIDTH-1]};
    end else if (cmd_i.skip || cmd_i.emit_digit) begin
      bcd_q <= {bcd_q[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
    end
  end

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_sign || cmd_i.emit_digit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_sign) begin
      char_q <= CHAR_MINUS;
      last_q <= 1'b0;
    end else if (cmd_i.emit_digit) begin
      char_q <= CHAR_ZERO + {2'b00, top_digit};
      last_q <= (dcnt_q == DCNT_W'(1));
    end
  end

  assign out_valid_o = out_valid_q;
  assign character_o = char_q;
  assign last_o      = last_q;

endmodule

@@ design/signed_int_to_decimal_ascii.sv @@
// Signed integer to decimal ASCII converter, top level.
// Input channel in_i carries one signed VALUE_WIDTH-bit value per beat.
// Output channel out_o carries one ASCII character per beat, most
// significant first: a minus sign for negative values, then the decimal
// digits with no leading zeros; the final character has last set.
// Zero gives the single character '0'; the most negative value converts
// exactly.
// One value is handled at a time. After the input beat, a bit-serial
// double-dabble loop shifts in the magnitude, the minus sign is sent
// for a negative value, leading zero digits are dropped at one a cycle,
// then one character leaves per cycle while the receiver takes them.
// The output register lets the next value be taken while the final
// character still waits. A stalled receiver holds the output beat and
// halts emission. Reset empties the output register and returns the
// controller to idle.
module signed_int_to_decimal_ascii #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  sidta_value_if.sink  in_i,
  sidta_char_if.source out_o
);
  import sidta_pkg::*;

  // enough digits for any VALUE_WIDTH-bit magnitude
  localparam int unsigned NUM_DIGITS = (VALUE_WIDTH * 30103) / 100000 + 1;

  sidta_cmd_t cmd;
  sidta_sts_t sts;

  // controller
  sidta_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath
  sidta_dp #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .NUM_DIGITS  (NUM_DIGITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .value_i     (in_i.value),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .character_o (out_o.character),
    .last_o      (out_o.last)
  );

endmodule
